>>> hdl/gfl_pkg.sv
// ----------------------------------------------------------------------------
// gfl_pkg
// Types and codes shared by the linked free list slot allocator.
// ----------------------------------------------------------------------------
package gfl_pkg;

	localparam int SlotW = 11;
	localparam int OpW   = 2;
	localparam int StatW = 2;

	localparam logic [OpW-1:0] OP_RESERVE = 2'd0;
	localparam logic [OpW-1:0] OP_RELEASE = 2'd1;
	localparam logic [OpW-1:0] OP_GROW    = 2'd2;

	localparam logic [StatW-1:0] STAT_OK      = 2'd0;
	localparam logic [StatW-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [StatW-1:0] STAT_REFUSED = 2'd2;

	typedef struct packed {
		logic [OpW-1:0]   opcode;
		logic [SlotW-1:0] slot_index;
		logic [SlotW-1:0] new_size;
	} req_t;

	typedef struct packed {
		logic [SlotW-1:0] granted_slot;
		logic [StatW-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RSV,
		S_REL_LINK,
		S_REL_CLR,
		S_GROW_LINK,
		S_GROW_FILL,
		S_RESP
	} state_t;

endpackage

>>> hdl/gfl_ram.sv
// ----------------------------------------------------------------------------
// gfl_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module gfl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/gfl_ctrl.sv
// ----------------------------------------------------------------------------
// gfl_ctrl
// Free list sequencer: head, tail and count registers plus the link memory.
// ----------------------------------------------------------------------------
module gfl_ctrl #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gfl_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output gfl_pkg::rsp_t res
);

	import gfl_pkg::*;

	localparam int Depth = MAX_SLOTS + 1;
	localparam int AW    = $clog2(Depth);
	localparam logic [16:0] MaxCap = 17'(MAX_SLOTS);

	state_t           state_q, state_d;
	logic [SlotW-1:0] head_q, head_d;
	logic [SlotW-1:0] tail_q, tail_d;
	logic [SlotW-1:0] count_q, count_d;
	logic [SlotW-1:0] idx_q, idx_d;
	logic [SlotW-1:0] arg_q, arg_d;
	logic [StatW-1:0] rstat_q, rstat_d;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [SlotW-1:0] wdata;
	logic [SlotW-1:0] rdata;

	gfl_ram #(
		.WIDTH(SlotW),
		.DEPTH(Depth)
	) u_link_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(AW'(head_q)),
		.rdata(rdata)
	);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		idx_d     = idx_q;
		arg_d     = arg_q;
		rstat_d   = rstat_q;
		req_stall = (state_q != S_IDLE);
		res_valid = 1'b0;
		res       = '0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.opcode)
						OP_RESERVE: begin
							if (head_q == '0) begin
								rstat_d = STAT_EMPTY;
								state_d = S_RESP;
							end else begin
								state_d = S_RSV;
							end
						end
						OP_RELEASE: begin
							if (req.slot_index == '0 || req.slot_index > count_q) begin
								rstat_d = STAT_REFUSED;
								state_d = S_RESP;
							end else begin
								arg_d   = req.slot_index;
								state_d = S_REL_LINK;
							end
						end
						OP_GROW: begin
							if (req.new_size < count_q || 17'(req.new_size) > MaxCap) begin
								rstat_d = STAT_REFUSED;
								state_d = S_RESP;
							end else if (req.new_size == count_q) begin
								rstat_d = STAT_OK;
								state_d = S_RESP;
							end else begin
								arg_d   = req.new_size;
								state_d = S_GROW_LINK;
							end
						end
						default: begin
							rstat_d = STAT_REFUSED;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_RSV: begin
				res_valid        = 1'b1;
				res.granted_slot = head_q;
				res.status       = STAT_OK;
				if (res_ready) begin
					we     = 1'b1;
					waddr  = AW'(head_q);
					wdata  = '0;
					head_d = rdata;
					if (rdata == '0) begin
						tail_d = '0;
					end
					state_d = S_IDLE;
				end
			end
			S_REL_LINK: begin
				if (tail_q == '0) begin
					head_d = arg_q;
				end else begin
					we    = 1'b1;
					waddr = AW'(tail_q);
					wdata = arg_q;
				end
				state_d = S_REL_CLR;
			end
			S_REL_CLR: begin
				res_valid  = 1'b1;
				res.status = STAT_OK;
				if (res_ready) begin
					we      = 1'b1;
					waddr   = AW'(arg_q);
					wdata   = '0;
					tail_d  = arg_q;
					state_d = S_IDLE;
				end
			end
			S_GROW_LINK: begin
				if (tail_q == '0) begin
					head_d = count_q + 1'b1;
				end else begin
					we    = 1'b1;
					waddr = AW'(tail_q);
					wdata = count_q + 1'b1;
				end
				idx_d   = count_q + 1'b1;
				state_d = S_GROW_FILL;
			end
			S_GROW_FILL: begin
				if (idx_q != arg_q) begin
					we    = 1'b1;
					waddr = AW'(idx_q);
					wdata = idx_q + 1'b1;
					idx_d = idx_q + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res.status = STAT_OK;
					if (res_ready) begin
						we      = 1'b1;
						waddr   = AW'(idx_q);
						wdata   = '0;
						tail_d  = arg_q;
						count_d = arg_q;
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				res_valid  = 1'b1;
				res.status = rstat_q;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		arg_q   <= arg_d;
		rstat_q <= rstat_d;
	end

endmodule

>>> hdl/growable_free_list_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// growable_free_list_slot_allocator_top
// Slot allocator over a singly linked free list kept in a link RAM.
//
//   Channel  Signals                      Content
//   req      req_valid, req_stall, req    opcode, slot_index, new_size
//   rsp      rsp_valid, rsp_stall, rsp    granted_slot, status
//
// One request is in work at a time; the link RAM's single write port sets the pace.
// Release links the slot after the tail, then clears its own link.
// Results sit in an output register, so a request can start while one waits.
// Reset clears the head, tail and slot count; the link RAM needs no clearing.
// A stalled result holds the sequencer in its final step until the register frees.
// ----------------------------------------------------------------------------
module growable_free_list_slot_allocator_top #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gfl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gfl_pkg::rsp_t rsp
);

	import gfl_pkg::*;

	logic res_valid;
	logic res_ready;
	rsp_t res;
	logic out_valid_q;
	rsp_t out_q;

	gfl_ctrl #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A granted slot always comes with a good status.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted_slot != '0 |-> rsp.status == STAT_OK)
		else $error("slot granted with a failing status");

	// The sequencer holds off new requests right after a transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while the previous one is in work");

	// A granted slot never lies beyond capacity.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 17'(rsp.granted_slot) <= 17'(MAX_SLOTS))
		else $error("granted slot beyond capacity");

	// A stalled response is held valid and unchanged in the output register.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("output register overwritten while stalled");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked free list slot allocator. A queue of
// requests feeds a clocked driver; a clocked monitor checks every response
// against a predictor of the link table, tail and slot count. Directed
// corner cases first, then random traffic that also frees granted slots.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gfl_pkg::*;

	localparam int MAX_SLOTS = 1024;
	localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1870;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned CALM_FROM = 2000;
	localparam int unsigned CALM_TO = 3500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [SlotW-1:0] next_free [0:MAX_SLOTS];
	int unsigned list_tail = 0;
	int unsigned slots_made = 0;

	req_t req_backlog [$];
	rsp_t outcome_q [$];
	int unsigned granted_pool [$];
	bit track_grants = 1'b0;
	int unsigned gen_slots = 0;

	int unsigned req_issued = 0;
	int unsigned req_done = 0;
	int unsigned mismatches = 0;
	int unsigned cycle = 0;
	rsp_t want;

	growable_free_list_slot_allocator_top #(
		.MAX_SLOTS(MAX_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic bit take_break();
		if (cycle >= CALM_FROM && cycle < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 15;
	endfunction

	function automatic rsp_t alloc_outcome(req_t r);
		rsp_t res;
		int unsigned head;
		int unsigned slot;
		int unsigned size;
		res.granted_slot = '0;
		res.status = STAT_OK;
		slot = 32'(r.slot_index);
		size = 32'(r.new_size);
		case (r.opcode)
			OP_RESERVE: begin
				head = 32'(next_free[0]);
				if (head == 0 || head > MAX_SLOTS) begin
					res.status = STAT_EMPTY;
				end else begin
					next_free[0] = next_free[head];
					next_free[head] = '0;
					if (next_free[0] == '0)
						list_tail = 0;
					res.granted_slot = SlotW'(head);
				end
			end
			OP_RELEASE: begin
				if (slot == 0 || slot > slots_made || slot > MAX_SLOTS) begin
					res.status = STAT_REFUSED;
				end else begin
					next_free[list_tail] = SlotW'(slot);
					next_free[slot] = '0;
					list_tail = slot;
				end
			end
			OP_GROW: begin
				if (size < slots_made || size > MAX_SLOTS) begin
					res.status = STAT_REFUSED;
				end else if (size > slots_made) begin
					for (int unsigned i = slots_made + 1; i < size; i++)
						next_free[i] = SlotW'(i + 1);
					next_free[size] = '0;
					next_free[list_tail] = SlotW'(slots_made + 1);
					list_tail = size;
					slots_made = size;
				end
			end
			default: begin
				res.status = STAT_REFUSED;
			end
		endcase
		return res;
	endfunction

	task automatic queue_req(logic [OpW-1:0] op, int unsigned slot, int unsigned size);
		req_t item;
		while (req_backlog.size() >= 3)
			@(posedge clk);
		item.opcode = op;
		item.slot_index = SlotW'(slot);
		item.new_size = SlotW'(size);
		if (op == OP_GROW && item.new_size >= gen_slots && item.new_size <= MAX_SLOTS)
			gen_slots = 32'(item.new_size);
		req_backlog = {req_backlog, item};
	endtask

	task automatic drain();
		while (req_backlog.size() != 0 || req_done != req_issued)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i <= MAX_SLOTS; i++)
			next_free[i] = '0;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			rsp_stall <= take_break();
			if (req_done == req_issued) begin
				if (req_backlog.size() != 0 && !take_break()) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					req_issued = req_issued + 1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			outcome_q = {outcome_q, alloc_outcome(req)};
			req_done = req_done + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected response: granted_slot %0d status %0d",
						rsp.granted_slot, rsp.status);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				if (rsp.granted_slot !== want.granted_slot || rsp.status !== want.status) begin
					if (mismatches < 10)
						$display("Mismatch: granted_slot exp %0d got %0d, status exp %0d got %0d",
							want.granted_slot, rsp.granted_slot, want.status, rsp.status);
					mismatches++;
				end
				if (track_grants && rsp.status == STAT_OK && rsp.granted_slot != '0)
					granted_pool = {granted_pool, 32'(rsp.granted_slot)};
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned idx;
		int unsigned size;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RELEASE, 0, 0);
		queue_req(OP_RELEASE, 1, 0);
		queue_req(OP_GROW, 2047, 0);
		queue_req(OP_UNUSED, 2047, 2047);
		queue_req(OP_GROW, 0, 2047);
		queue_req(OP_GROW, 0, MAX_SLOTS + 1);
		queue_req(OP_GROW, 0, 3);
		queue_req(OP_GROW, 0, 2);
		queue_req(OP_GROW, 0, 3);
		queue_req(OP_RELEASE, 4, 0);
		queue_req(OP_RELEASE, 2047, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RELEASE, 2, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RELEASE, 3, 0);
		queue_req(OP_RELEASE, 3, 0);
		queue_req(OP_RELEASE, 1, 0);
		queue_req(OP_GROW, 0, 5);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RESERVE, 0, 0);
		drain();
		track_grants = 1'b1;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75 && pick >= 40 && granted_pool.size() != 0) begin
				idx = $urandom_range(0, granted_pool.size() - 1);
				queue_req(OP_RELEASE, granted_pool[idx], $urandom_range(0, 2047));
				granted_pool.delete(idx);
			end else if (pick < 75) begin
				queue_req(OP_RESERVE, $urandom_range(0, 2047), $urandom_range(0, 2047));
			end else if (pick < 88) begin
				idx = $urandom_range(0, 9);
				if (idx < 7)
					size = gen_slots + $urandom_range(0, 8);
				else if (idx == 7)
					size = gen_slots + $urandom_range(9, 64);
				else if (idx == 8)
					size = gen_slots - $urandom_range(0, gen_slots);
				else
					size = $urandom_range(0, 2047);
				queue_req(OP_GROW, $urandom_range(0, 2047), size);
			end else if (pick < 93) begin
				queue_req(OP_RELEASE, $urandom_range(0, gen_slots + 2), $urandom_range(0, 2047));
			end else begin
				queue_req(OpW'(OP_UNUSED - $urandom_range(0, 3)), $urandom_range(0, 2047),
					$urandom_range(0, 2047));
			end
		end

		queue_req(OP_GROW, 0, MAX_SLOTS);
		queue_req(OP_GROW, 0, MAX_SLOTS);
		queue_req(OP_GROW, 0, MAX_SLOTS + 1);
		queue_req(OP_RELEASE, MAX_SLOTS, 0);
		queue_req(OP_RESERVE, 0, 0);
		queue_req(OP_RESERVE, 0, 0);
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
